>>> sv/bcoe_pkg.sv
package bcoe_pkg;

  localparam int QW    = 48;
  localparam int PW    = 96;
  localparam int HW    = 24;
  localparam int STEPS = 48;

  typedef logic signed [QW-1:0] q_t;

  typedef struct packed {
    logic signed [QW-1:0] re;
    logic signed [QW-1:0] im;
  } cx_t;

  localparam q_t QMAX      = 48'sh7FFF_FFFF_FFFF;
  localparam q_t QMIN      = 48'sh8000_0000_0000;
  localparam q_t ONE_Q     = 48'sh0001_0000_0000;
  localparam q_t HALF_NEG  = 48'shFFFF_8000_0000;
  localparam q_t QUART_NEG = 48'shFFFF_C000_0000;

  localparam logic [PW-1:0] ESC_NORM = 96'h64_0000_0000_0000_0000;
  localparam logic [PW-1:0] ONE_WIDE = 96'h1_0000_0000;
  localparam logic [3:0]    MOD15_LAST = 4'd14;

  // floor(n / 5) = (n * RECIP5) >> RECIP5_SH for n below 2^34
  localparam q_t RECIP5    = 48'sh0001_9999_999A;
  localparam int RECIP5_SH = 35;

  localparam logic [1:0] REG_LAMBDA_RE = 2'd0;
  localparam logic [1:0] REG_LAMBDA_IM = 2'd1;
  localparam logic [1:0] REG_MAX_ITER  = 2'd2;

  function automatic q_t sat49(logic [QW:0] s);
    if (s[QW] != s[QW-1]) begin
      return s[QW] ? QMIN : QMAX;
    end
    return s[QW-1:0];
  endfunction

  function automatic cx_t cadd(cx_t a, cx_t b);
    cx_t r;
    r.re = sat49({a.re[QW-1], a.re} + {b.re[QW-1], b.re});
    r.im = sat49({a.im[QW-1], a.im} + {b.im[QW-1], b.im});
    return r;
  endfunction

  function automatic q_t fmag(logic neg, logic [63:0] m);
    if (neg) begin
      if (m > 64'h8000_0000_0000) begin
        return QMIN;
      end
      return -m[QW-1:0];
    end
    if (m > 64'h7FFF_FFFF_FFFF) begin
      return QMAX;
    end
    return m[QW-1:0];
  endfunction

  function automatic logic [QW-1:0] mag(q_t v);
    return v[QW-1] ? -v : v;
  endfunction

endpackage

>>> sv/biquad_critical_orbit_escape.sv
// Escape-time test of one parameter point t for the quartic critical-orbit family. One point
// is taken at a time; in_ready is high only while the block is idle, and the finished word
// waits in an output register so the next point can be taken meanwhile. All arithmetic runs
// on one 24x24 multiplier that forms each exact real product from four partial products,
// plus a 48-step shift-subtract unit for the setup divisions and square roots. Each orbit
// step is four complex multiplies and a magnitude check.
module biquad_critical_orbit_escape #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 28
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] in_point_re,
  input  logic signed [COORD_WIDTH-1:0] in_point_im,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_both_bounded,
  output logic [7:0]                    out_colour_code,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [COORD_WIDTH-1:0]        cfg_data
);

  localparam int QW  = bcoe_pkg::QW;
  localparam int PW  = bcoe_pkg::PW;
  localparam int HW  = bcoe_pkg::HW;
  localparam int LSH = (FRAC_BITS < 32) ? 32 - FRAC_BITS : 0;
  localparam int RSH = (FRAC_BITS > 32) ? FRAC_BITS - 32 : 0;
  localparam logic [COORD_WIDTH-1:0] LRE_RST = COORD_WIDTH'(64'd241591910);
  localparam logic [2:0] PH_LOAD = 3'd0;
  localparam logic [2:0] PH_FIN  = 3'd5;
  localparam logic [5:0] STEP_LAST = 6'(bcoe_pkg::STEPS - 1);

  typedef enum logic [4:0] {
    S_IDLE, S_START, S_DEN, S_QRE, S_QIM, S_QDONE, S_A, S_X0, S_QQ, S_CV,
    S_LNORM, S_LSQ, S_LMAG, S_TSQ, S_TMAG, S_MDIV, S_K5, S_KMUL, S_KDONE,
    S_OINIT, S_OTEST, S_S1, S_S2, S_S3, S_S4, S_OCAP, S_OEND, S_DONE,
    S_MUL, S_DIV, S_SQRT
  } state_t;

  typedef enum logic [1:0] {M_CMUL, M_NORM, M_EXACT} mode_t;

  function automatic bcoe_pkg::q_t to_q(logic [COORD_WIDTH-1:0] raw);
    logic signed [PW-1:0] v;
    v = {{(PW-COORD_WIDTH){raw[COORD_WIDTH-1]}}, raw};
    v = (v <<< LSH) >>> RSH;
    if (!v[PW-1] && v[PW-2:QW-1] != '0) begin
      return bcoe_pkg::QMAX;
    end
    if (v[PW-1] && v[PW-2:QW-1] != '1) begin
      return bcoe_pkg::QMIN;
    end
    return v[QW-1:0];
  endfunction

  state_t state_r, ret_r;
  mode_t  mode_r;

  logic [COORD_WIDTH-1:0] lre_r, lim_r;
  logic [7:0]             max_iter_r;

  bcoe_pkg::cx_t lam_r, t_r, q_r, a_r, b_r, c_r, x0_r, cv_r, x_r, res_r;
  bcoe_pkg::cx_t opa_r, opb_r;
  bcoe_pkg::q_t  tmp_r, lmag_r, m_r;
  logic          tz_r, attr_r;
  logic [PW-1:0] nrm_r, den_r, kth_r;
  logic signed [PW+1:0] er_r, ei_r;

  logic [1:0]    j_r;
  logic [2:0]    ph_r;
  logic [QW-1:0] ma_r, mb_r;
  logic          mneg_r;
  logic [PW-1:0] acc_r;

  logic [PW:0]   div_rem_r;
  logic [QW-1:0] div_num_r, div_q_r;
  logic [PW-1:0] div_d_r;
  logic          div_over_r;
  logic [5:0]    step_cnt_r;

  logic [PW-1:0] rad_r;
  logic [QW+1:0] srem_r;
  logic [QW-1:0] root_r;

  logic          o_r, esc0_r, esc1_r;
  logic [7:0]    cnt_r;
  logic [3:0]    c15_r, col0_r, col1_r;

  logic          out_valid_r, out_bb_r;
  logic [7:0]    out_col_r;

  // multiplier datapath
  bcoe_pkg::q_t   asel, bsel, fval;
  logic [1:0]     kk;
  logic [HW-1:0]  ah, bh;
  logic [2*HW-1:0] pp;
  logic [5:0]     shamt;
  logic [PW-1:0]  acc_sum;
  logic signed [PW+1:0] sp;
  logic           mul_last;

  always_comb begin
    asel = j_r[0] ? opa_r.im : opa_r.re;
    bsel = (j_r[0] ^ j_r[1]) ? opb_r.im : opb_r.re;
    kk = 2'(ph_r - 3'd1);
    ah = kk[1] ? ma_r[QW-1:HW] : ma_r[HW-1:0];
    bh = kk[0] ? mb_r[QW-1:HW] : mb_r[HW-1:0];
    pp = ah * bh;
    case (kk)
      2'd0:    shamt = 6'd0;
      2'd3:    shamt = 6'(2 * HW);
      default: shamt = 6'(HW);
    endcase
    acc_sum = ((ph_r == 3'd1) ? '0 : acc_r) + (PW'(pp) << shamt);
    fval = bcoe_pkg::fmag(mneg_r, acc_r[PW-1:32]);
    sp = mneg_r ? -$signed({2'b00, acc_r}) : $signed({2'b00, acc_r});
    mul_last = (mode_r == M_NORM) ? (j_r == 2'd1) : (j_r == 2'd3);
  end

  // divider and square root steps
  logic [PW-1:0] dn, dd;
  logic          d_over;
  logic [PW+1:0] dsh, ddif;
  logic          dge;
  logic [48:0]   div_res;
  logic [QW+3:0] s2, strial, sdif;
  logic          sge;
  logic [QW-1:0] root_sat;

  always_comb begin
    case (state_r)
      S_QRE:   dn = er_r[PW+1] ? PW'(-er_r) : PW'(er_r);
      S_QIM:   dn = ei_r[PW+1] ? PW'(-ei_r) : PW'(ei_r);
      default: dn = bcoe_pkg::ONE_WIDE;
    endcase
    root_sat = root_r[QW-1] ? bcoe_pkg::QMAX : root_r;
    dd = (state_r == S_TMAG) ? PW'(root_sat) : den_r;
    d_over = {16'b0, dn} >= {dd, 16'b0};
    dsh = {div_rem_r, div_num_r[QW-1]};
    ddif = dsh - {2'b00, div_d_r};
    dge = dsh >= {2'b00, div_d_r};
    div_res = div_over_r ? 49'h1_0000_0000_0000 : {1'b0, div_q_r};
    s2 = {srem_r, rad_r[PW-1:PW-2]};
    strial = {2'b00, root_r, 2'b01};
    sdif = s2 - strial;
    sge = s2 >= strial;
  end

  assign in_ready = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_both_bounded = out_bb_r;
  assign out_colour_code = out_col_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid_r <= 1'b0;
      j_r <= '0;
      ph_r <= PH_LOAD;
      step_cnt_r <= '0;
      lre_r <= LRE_RST;
      lim_r <= '0;
      max_iter_r <= 8'd50;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          bcoe_pkg::REG_LAMBDA_RE: lre_r <= cfg_data;
          bcoe_pkg::REG_LAMBDA_IM: lim_r <= cfg_data;
          bcoe_pkg::REG_MAX_ITER:  max_iter_r <= cfg_data[7:0];
          default: ;
        endcase
      end
      if (out_valid_r && out_ready && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            t_r.re <= to_q(in_point_re);
            t_r.im <= to_q(in_point_im);
            lam_r.re <= to_q(lre_r);
            lam_r.im <= to_q(lim_r);
            state_r <= S_START;
          end
        end
        S_START: begin
          tz_r <= (t_r.re == 0) && (t_r.im == 0);
          if ((t_r.re == 0) && (t_r.im == 0)) begin
            a_r <= '{bcoe_pkg::ONE_Q, '0};
            b_r <= '0;
            c_r <= '0;
            x0_r <= '{bcoe_pkg::HALF_NEG, '0};
            cv_r <= '0;
            state_r <= S_LNORM;
          end else begin
            opa_r <= t_r; opb_r <= t_r; mode_r <= M_NORM;
            ret_r <= S_DEN; state_r <= S_MUL;
          end
        end
        S_DEN: begin
          den_r <= nrm_r;
          opa_r <= lam_r; opb_r <= t_r; mode_r <= M_EXACT;
          ret_r <= S_QRE; state_r <= S_MUL;
        end
        S_QRE: begin
          div_over_r <= d_over;
          div_rem_r <= {17'b0, dn[PW-1:16]};
          div_num_r <= {dn[15:0], 32'b0};
          div_d_r <= dd;
          ret_r <= S_QIM; state_r <= S_DIV;
        end
        S_QIM: begin
          q_r.re <= bcoe_pkg::fmag(er_r[PW+1], 64'(div_res));
          div_over_r <= d_over;
          div_rem_r <= {17'b0, dn[PW-1:16]};
          div_num_r <= {dn[15:0], 32'b0};
          div_d_r <= dd;
          ret_r <= S_QDONE; state_r <= S_DIV;
        end
        S_QDONE: begin
          q_r.im <= bcoe_pkg::fmag(ei_r[PW+1], 64'(div_res));
          opa_r <= t_r; opb_r <= t_r; mode_r <= M_CMUL;
          ret_r <= S_A; state_r <= S_MUL;
        end
        S_A: begin
          a_r <= bcoe_pkg::cadd(q_r, res_r);
          b_r <= bcoe_pkg::cadd(t_r, t_r);
          c_r <= '{bcoe_pkg::ONE_Q, '0};
          opa_r <= t_r; opb_r <= '{bcoe_pkg::HALF_NEG, '0}; mode_r <= M_CMUL;
          ret_r <= S_X0; state_r <= S_MUL;
        end
        S_X0: begin
          x0_r <= res_r;
          opa_r <= q_r; opb_r <= q_r; mode_r <= M_CMUL;
          ret_r <= S_QQ; state_r <= S_MUL;
        end
        S_QQ: begin
          opa_r <= res_r; opb_r <= '{bcoe_pkg::QUART_NEG, '0}; mode_r <= M_CMUL;
          ret_r <= S_CV; state_r <= S_MUL;
        end
        S_CV: begin
          cv_r <= res_r;
          state_r <= S_LNORM;
        end
        S_LNORM: begin
          opa_r <= lam_r; opb_r <= lam_r; mode_r <= M_NORM;
          ret_r <= S_LSQ; state_r <= S_MUL;
        end
        S_LSQ, S_TSQ: begin
          rad_r <= nrm_r;
          srem_r <= '0;
          root_r <= '0;
          ret_r <= (state_r == S_LSQ) ? S_LMAG : S_TMAG;
          state_r <= S_SQRT;
        end
        S_LMAG: begin
          lmag_r <= root_sat;
          attr_r <= (root_r[QW-1:32] == 0);
          if (root_r[QW-1:32] == 0) begin
            opa_r <= t_r; opb_r <= t_r; mode_r <= M_NORM;
            ret_r <= S_TSQ; state_r <= S_MUL;
          end else begin
            state_r <= S_OINIT;
          end
        end
        S_TMAG: begin
          if (root_r[QW-1:32] == 0) begin
            m_r <= root_r;
            state_r <= S_K5;
          end else begin
            div_over_r <= d_over;
            div_rem_r <= {17'b0, dn[PW-1:16]};
            div_num_r <= {dn[15:0], 32'b0};
            div_d_r <= dd;
            ret_r <= S_MDIV; state_r <= S_DIV;
          end
        end
        S_MDIV: begin
          m_r <= bcoe_pkg::fmag(1'b0, 64'(div_res));
          state_r <= S_K5;
        end
        S_K5: begin
          opa_r <= '{bcoe_pkg::ONE_Q - lmag_r, '0};
          opb_r <= '{bcoe_pkg::RECIP5, '0}; mode_r <= M_NORM;
          ret_r <= S_KMUL; state_r <= S_MUL;
        end
        S_KMUL: begin
          opa_r <= '{nrm_r[QW+bcoe_pkg::RECIP5_SH-1:bcoe_pkg::RECIP5_SH], '0};
          opb_r <= '{m_r, '0}; mode_r <= M_CMUL;
          ret_r <= S_KDONE; state_r <= S_MUL;
        end
        S_KDONE: begin
          kth_r <= PW'({res_r.re, 32'b0});
          state_r <= S_OINIT;
        end
        S_OINIT: begin
          o_r <= 1'b0;
          x_r <= x0_r;
          cnt_r <= '0;
          c15_r <= '0;
          opa_r <= x0_r; opb_r <= x0_r; mode_r <= M_NORM;
          ret_r <= S_OTEST; state_r <= S_MUL;
        end
        S_OTEST: begin
          if (cnt_r < max_iter_r && nrm_r < bcoe_pkg::ESC_NORM) begin
            opa_r <= x_r; opb_r <= c_r; mode_r <= M_CMUL;
            ret_r <= S_S1; state_r <= S_MUL;
          end else begin
            if (o_r) begin
              esc1_r <= cnt_r < max_iter_r;
              col1_r <= c15_r + 4'd1;
            end else begin
              esc0_r <= cnt_r < max_iter_r;
              col0_r <= c15_r + 4'd1;
            end
            state_r <= S_OEND;
          end
        end
        S_S1: begin
          opa_r <= x_r; opb_r <= bcoe_pkg::cadd(b_r, res_r); mode_r <= M_CMUL;
          ret_r <= S_S2; state_r <= S_MUL;
        end
        S_S2: begin
          opa_r <= x_r; opb_r <= bcoe_pkg::cadd(a_r, res_r); mode_r <= M_CMUL;
          ret_r <= S_S3; state_r <= S_MUL;
        end
        S_S3: begin
          opa_r <= x_r; opb_r <= bcoe_pkg::cadd(lam_r, res_r); mode_r <= M_CMUL;
          ret_r <= S_S4; state_r <= S_MUL;
        end
        S_S4: begin
          x_r <= res_r;
          cnt_r <= cnt_r + 8'd1;
          c15_r <= (c15_r == bcoe_pkg::MOD15_LAST) ? 4'd0 : c15_r + 4'd1;
          opa_r <= res_r; opb_r <= res_r; mode_r <= M_NORM;
          ret_r <= S_OCAP; state_r <= S_MUL;
        end
        S_OCAP: begin
          if (attr_r && nrm_r < kth_r) begin
            if (o_r) begin
              esc1_r <= 1'b0;
            end else begin
              esc0_r <= 1'b0;
            end
            state_r <= S_OEND;
          end else begin
            state_r <= S_OTEST;
          end
        end
        S_OEND: begin
          if (!o_r && !tz_r && (a_r.re != 0 || a_r.im != 0)) begin
            o_r <= 1'b1;
            x_r <= cv_r;
            cnt_r <= '0;
            c15_r <= '0;
            opa_r <= cv_r; opb_r <= cv_r; mode_r <= M_NORM;
            ret_r <= S_OTEST; state_r <= S_MUL;
          end else begin
            if (!o_r) begin
              esc1_r <= 1'b0;
            end
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_bb_r <= !esc0_r && !esc1_r;
            out_col_r <= {esc0_r ? col0_r : 4'd0, esc1_r ? col1_r : 4'd0};
            state_r <= S_IDLE;
          end
        end
        S_MUL: begin
          if (ph_r == PH_LOAD) begin
            ma_r <= bcoe_pkg::mag(asel);
            mb_r <= bcoe_pkg::mag(bsel);
            mneg_r <= asel[QW-1] ^ bsel[QW-1];
            ph_r <= 3'd1;
          end else if (ph_r != PH_FIN) begin
            acc_r <= acc_sum;
            ph_r <= ph_r + 3'd1;
          end else begin
            case (mode_r)
              M_CMUL: begin
                case (j_r)
                  2'd0, 2'd2: tmp_r <= fval;
                  2'd1: res_r.re <= bcoe_pkg::sat49({tmp_r[QW-1], tmp_r} - {fval[QW-1], fval});
                  default: res_r.im <= bcoe_pkg::sat49({tmp_r[QW-1], tmp_r} + {fval[QW-1], fval});
                endcase
              end
              M_NORM: begin
                nrm_r <= (j_r == 2'd0) ? acc_r : nrm_r + acc_r;
              end
              M_EXACT: begin
                case (j_r)
                  2'd0:    er_r <= sp;
                  2'd1:    er_r <= er_r + sp;
                  2'd2:    ei_r <= -sp;
                  default: ei_r <= ei_r + sp;
                endcase
              end
              default: ;
            endcase
            ph_r <= PH_LOAD;
            if (mul_last) begin
              j_r <= '0;
              state_r <= ret_r;
            end else begin
              j_r <= j_r + 2'd1;
            end
          end
        end
        S_DIV: begin
          div_rem_r <= dge ? ddif[PW:0] : dsh[PW:0];
          div_q_r <= {div_q_r[QW-2:0], dge};
          div_num_r <= {div_num_r[QW-2:0], 1'b0};
          if (step_cnt_r == STEP_LAST) begin
            step_cnt_r <= '0;
            state_r <= ret_r;
          end else begin
            step_cnt_r <= step_cnt_r + 6'd1;
          end
        end
        S_SQRT: begin
          srem_r <= sge ? sdif[QW+1:0] : s2[QW+1:0];
          root_r <= {root_r[QW-2:0], sge};
          rad_r <= {rad_r[PW-3:0], 2'b00};
          if (step_cnt_r == STEP_LAST) begin
            step_cnt_r <= '0;
            state_r <= ret_r;
          end else begin
            step_cnt_r <= step_cnt_r + 6'd1;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_bounded_blank: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_both_bounded |-> out_colour_code == 8'd0)
    else $error("bounded word carries a colour");

  a_escape_coloured: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_both_bounded |-> out_colour_code != 8'd0)
    else $error("escaping word has no colour");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready right after accepting a point");

endmodule
